[src/b38d_pkg.sv]
// Shared types, constants and helper functions for the base-38 identifier decoder.
// No dependencies; imported by every module under src.
package b38d_pkg;

	// Field and word widths
	localparam int WORD_W   = 64;
	localparam int HALF_W   = 32;
	localparam int DIGIT_W  = 6;
	localparam int COUNT_W  = 4;
	localparam int CHAR_W   = 8;
	localparam int CHARS_W  = 64;
	localparam int BOUND_W  = 128;

	// Radix and digit limits
	localparam int unsigned RADIX       = 38;
	localparam int unsigned MAX_DIGITS  = 8;
	localparam int unsigned SHORT_SHIFT = 5;
	localparam int unsigned LONG_SHIFT  = 6;
	localparam logic [COUNT_W-1:0] SHORT_LIMIT = 4'd5;
	localparam logic [COUNT_W-1:0] LONG_LIMIT  = 4'd8;
	localparam logic [COUNT_W-1:0] LONG_LIMIT_EFF =
		(MAX_DIGITS < LONG_LIMIT) ? COUNT_W'(MAX_DIGITS) : LONG_LIMIT;

	// Mode codes
	localparam logic MODE_SHORT = 1'b0;
	localparam logic MODE_LONG  = 1'b1;

	// Chunked division by 38: 2^32 = 38 * WRAP_QUOT + WRAP_REM
	localparam logic [HALF_W-1:0] WRAP_QUOT = 32'd113025455;
	localparam logic [2:0]        WRAP_REM  = 3'd6;
	// Reciprocal of 19 for numerators below 2^32: ceil(2^37 / 19)
	localparam logic [HALF_W:0]   RECIP_M     = 33'd7233629131;
	localparam int                RECIP_SHIFT = 37;
	localparam int                QF_W        = 28;

	// Character map anchors
	localparam logic [CHAR_W-1:0]  CHAR_ZERO         = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A            = 8'h41;
	localparam logic [DIGIT_W-1:0] DIGIT_FIRST_NUM   = 6'd2;
	localparam logic [DIGIT_W-1:0] DIGIT_FIRST_ALPHA = 6'd12;

	// Input and result items
	typedef struct packed {
		logic [WORD_W-1:0] packed_word;
		logic              mode;
		logic              no_shift;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] char_count;
		logic [CHARS_W-1:0] chars;
		logic               overflow;
	} out_item_t;

	// Divide unit request and response
	typedef struct packed {
		logic [DIGIT_W-1:0] rem;
		logic [HALF_W-1:0]  chunk;
	} div_req_t;

	typedef struct packed {
		logic [HALF_W-1:0]  quot;
		logic [DIGIT_W-1:0] rem;
	} div_rsp_t;

	// Raise the radix to a power at elaboration
	function automatic logic [BOUND_W-1:0] b38d_radix_pow(input int unsigned n);
		logic [BOUND_W-1:0] p;
		p = BOUND_W'(1);
		for (int unsigned i = 0; i < n; i++) begin
			p = p * BOUND_W'(RADIX);
		end
		return p;
	endfunction

	// Values at or above this bound need more digits than allowed
	localparam logic [BOUND_W-1:0] OVF_BOUND = b38d_radix_pow(MAX_DIGITS);

	// Map one digit to its character code
	function automatic logic [CHAR_W-1:0] b38d_digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d >= DIGIT_FIRST_NUM && d < DIGIT_FIRST_ALPHA) begin
			return CHAR_ZERO + dx - CHAR_W'(DIGIT_FIRST_NUM);
		end
		return CHAR_A + dx - CHAR_W'(DIGIT_FIRST_ALPHA);
	endfunction

endpackage

[src/base38_identifier_decoder.sv]
// Top level of the base-38 identifier decoder: sequencer, value registers, result register.
// Depends on b38d_pkg and b38d_div38.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------
//  item     | in        | item_valid / item_stall     | in_item_t
//  result   | out       | result_valid / result_stall | out_item_t
//
// One item at a time. Per item: a load, an issue, then per digit one divide of the low
// chunk while the upper 32 bits of the value are zero, else one of each chunk, then a result write.
// Short mode gives at most 5 digits, long mode at most 8; an over-long value skips the divides.
// Each divide goes through the two-stage divide unit, issued once per 32-bit chunk.
// Reset clears the sequencer and the result valid flag. A stalled result is held in the
// output register; the next item is taken meanwhile and waits there before writing.
module base38_identifier_decoder import b38d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_HI_WAIT,
		ST_LO_WAIT,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic               res_valid_q;
	out_item_t          res_q;
	logic [HALF_W-1:0]  val_hi_q;
	logic [HALF_W-1:0]  val_lo_q;
	logic [COUNT_W-1:0] lim_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [CHARS_W-1:0] chars_q;
	logic               ovf_q;

	logic [WORD_W-1:0]  red;
	logic               ovf;
	logic               accept;
	logic               out_free;
	logic               hi_pending;
	logic [COUNT_W-1:0] cnt_inc;
	logic               more;
	logic               issue;
	div_req_t           req;
	logic               done;
	div_rsp_t           rsp;

	// Reduce the packed word according to mode and shift flag
	always_comb begin
		if (item.mode == MODE_LONG) begin
			red = item.no_shift ? item.packed_word : (item.packed_word >> LONG_SHIFT);
		end else begin
			red = item.no_shift ? {32'd0, item.packed_word[HALF_W-1:0]}
				: ({32'd0, item.packed_word[HALF_W-1:0]} >> SHORT_SHIFT);
		end
	end

	assign ovf        = {64'd0, red} >= OVF_BOUND;
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !res_valid_q || !result_stall;
	assign hi_pending = (val_hi_q != '0);
	assign cnt_inc    = cnt_q + 4'd1;
	assign more       = (rsp.rem != '0) && (cnt_inc != lim_q);

	// Select the next chunk for the divide unit
	always_comb begin
		issue = 1'b0;
		req   = '0;
		unique case (state_q)
			ST_START: begin
				issue     = 1'b1;
				req.chunk = hi_pending ? val_hi_q : val_lo_q;
			end
			ST_HI_WAIT: begin
				issue     = done;
				req.rem   = rsp.rem;
				req.chunk = val_lo_q;
			end
			ST_LO_WAIT: begin
				issue     = done && more;
				req.chunk = hi_pending ? val_hi_q : rsp.quot;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	b38d_div38 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (issue),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Sequencer, result register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// Raise valid on a new result, drop it once the result is taken
			if (state_q == ST_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ovf ? ST_FINISH : ST_START;
					end
				end
				ST_START: begin
					state_q <= hi_pending ? ST_HI_WAIT : ST_LO_WAIT;
				end
				ST_HI_WAIT: begin
					if (done) begin
						state_q <= ST_LO_WAIT;
					end
				end
				ST_LO_WAIT: begin
					if (done) begin
						if (!more) begin
							state_q <= ST_FINISH;
						end else if (hi_pending) begin
							state_q <= ST_HI_WAIT;
						end else begin
							state_q <= ST_LO_WAIT;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						res_q.char_count <= cnt_q;
						res_q.chars      <= chars_q;
						res_q.overflow   <= ovf_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Value, digit count and character registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_hi_q <= red[WORD_W-1:HALF_W];
			val_lo_q <= red[HALF_W-1:0];
			lim_q    <= (item.mode == MODE_LONG) ? LONG_LIMIT_EFF : SHORT_LIMIT;
			cnt_q    <= '0;
			chars_q  <= '0;
			ovf_q    <= ovf;
		end
		if (state_q == ST_HI_WAIT && done) begin
			val_hi_q <= rsp.quot;
		end
		// Prepend each new digit: the last digit found is the leftmost character
		if (state_q == ST_LO_WAIT && done) begin
			val_lo_q <= rsp.quot;
			if (rsp.rem != '0) begin
				chars_q <= {chars_q[CHARS_W-CHAR_W-1:0], b38d_digit_char(rsp.rem)};
				cnt_q   <= cnt_inc;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[src/b38d_div38.sv]
// Two-stage divide-by-38 unit for one 32-bit chunk with a carried-in remainder.
// Depends on b38d_pkg (request/response types, reciprocal constants).
module b38d_div38 import b38d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  div_req_t req,
	output logic     done,
	output div_rsp_t rsp
);

	logic [HALF_W:0]         num;
	logic [2*HALF_W:0]       prod;
	logic [HALF_W-1:0]       rk;
	logic                    v_s1;
	logic [6:0]              num_lo_s1;
	logic [QF_W-1:0]         qf_s1;
	logic [HALF_W-1:0]       rk_s1;
	logic [6:0]              q38_lo;
	logic [6:0]              rem7;
	logic                    done_q;
	div_rsp_t                rsp_q;

	// Fold the carried remainder: (r*2^32 + c)/38 = r*WRAP_QUOT + (6r + c)/38
	assign num  = (33'(req.rem) * 33'(WRAP_REM)) + 33'(req.chunk);
	assign prod = 65'(num[HALF_W:1]) * 65'(RECIP_M);
	assign rk   = 32'(req.rem) * WRAP_QUOT;

	// Stage 1: reciprocal product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_lo_s1 <= num[6:0];
			qf_s1     <= prod[RECIP_SHIFT+QF_W-1:RECIP_SHIFT];
			rk_s1     <= rk;
		end
	end

	// Stage 2: remainder from the low bits only, since it stays below 38
	assign q38_lo = {qf_s1[1:0], 5'd0} + {qf_s1[4:0], 2'd0} + {qf_s1[5:0], 1'b0};
	assign rem7   = num_lo_s1 - q38_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			rsp_q.quot <= rk_s1 + 32'(qf_s1);
			rsp_q.rem  <= rem7[DIGIT_W-1:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
